FILE: hdl/wfs_pkg.sv
// Package: shared types, codes and constants of the waypoint follower.
`timescale 1ns / 1ps
package wfs_pkg;

  localparam int unsigned ROUTE_DEPTH_DEF = 16;
  localparam int unsigned CFG_W           = 24;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned COORD_W         = 32;
  localparam int unsigned DT_W            = 16;
  localparam int unsigned MODE_W          = 2;
  localparam int unsigned CMD_W           = 3;
  localparam int unsigned OUT_IDX_W       = 4;
  localparam int unsigned OUT_LEN_W       = 5;
  localparam int unsigned SNAP_RESET      = 256;

  // Radicand, root, remainder and operand widths of the shared unit
  localparam int unsigned RAD_W  = 66;
  localparam int unsigned ROOT_W = 33;
  localparam int unsigned REM_W  = 36;
  localparam int unsigned DEN_W  = 31;
  localparam int unsigned SQRT_STEPS = 33;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned STEP_CNT_W = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_MOVE_TO  = 3'd1,
    CMD_WITHDRAW = 3'd2,
    CMD_HALT     = 3'd3,
    CMD_APPEND   = 3'd4,
    CMD_SET_POS  = 3'd5,
    CMD_RSVD6    = 3'd6,
    CMD_RSVD7    = 3'd7
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE     = 2'd0,
    MODE_MOVING   = 2'd1,
    MODE_WITHDRAW = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SNAP  = 2'd0,
    REG_SPEED = 2'd1,
    REG_LOOP  = 2'd2
  } reg_e;

  // Control from the sequencer to the shared root/divide unit
  typedef struct packed {
    logic start;
    logic sqrt_op;
  } sqdiv_ctl_t;

endpackage

FILE: hdl/wfs_route_mem.sv
// Waypoint store: one write port, one registered read port.
`timescale 1ns / 1ps
module wfs_route_mem #(
  parameter int unsigned DEPTH = wfs_pkg::ROUTE_DEPTH_DEF,
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [IW-1:0]                waddr_i,
  input  logic [2*wfs_pkg::COORD_W-1:0] wdata_i,
  input  logic [IW-1:0]                raddr_i,
  output logic [2*wfs_pkg::COORD_W-1:0] rdata_o
);

  logic [2*wfs_pkg::COORD_W-1:0] mem_q [DEPTH];

  // Write a waypoint
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read the addressed waypoint
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/wfs_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
`timescale 1ns / 1ps
module wfs_mul (
  input  logic        clk_i,
  input  logic [31:0] op_a_i,
  input  logic [31:0] op_b_i,
  output logic [63:0] prod_o
);

  // Register the product
  always_ff @(posedge clk_i) begin
    prod_o <= {32'd0, op_a_i} * {32'd0, op_b_i};
  end

endmodule

FILE: hdl/wfs_sqdiv.sv
// Shared iterative unit: one bit per cycle of a square root or a division.
`timescale 1ns / 1ps
module wfs_sqdiv (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wfs_pkg::sqdiv_ctl_t                ctl_i,
  input  logic [wfs_pkg::RAD_W-1:0]          radicand_i,
  input  logic [63:0]                        dividend_i,
  input  logic [wfs_pkg::DEN_W-1:0]          divisor_i,
  output logic                               done_o,
  output logic [wfs_pkg::ROOT_W-1:0]         root_o,
  output logic [31:0]                        quot_o
);

  logic                              busy_q, busy_d;
  logic                              done_q, done_d;
  logic                              op_q, op_d;
  logic [wfs_pkg::STEP_CNT_W-1:0]    cnt_q, cnt_d;
  logic [wfs_pkg::RAD_W-1:0]         rad_q, rad_d;
  logic [wfs_pkg::REM_W-1:0]         rem_q, rem_d;
  logic [wfs_pkg::ROOT_W-1:0]        root_q, root_d;
  logic [wfs_pkg::DEN_W-1:0]         den_q, den_d;
  logic [wfs_pkg::REM_W-1:0]         sub_x, sub_y;
  logic [wfs_pkg::REM_W:0]           sub_r;
  logic                              ge;

  // Shared subtract and compare
  always_comb begin
    if (op_q) begin
      sub_x = {rem_q[wfs_pkg::REM_W-3:0], rad_q[wfs_pkg::RAD_W-1 -: 2]};
      sub_y = {1'b0, root_q, 2'b01};
    end else begin
      sub_x = {4'd0, rem_q[30:0], rad_q[31]};
      sub_y = {5'd0, den_q};
    end
    sub_r = {1'b0, sub_x} - {1'b0, sub_y};
    ge    = ~sub_r[wfs_pkg::REM_W];
  end

  // Load on start, then take one bit per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    den_d  = den_q;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      op_d   = ctl_i.sqrt_op;
      den_d  = divisor_i;
      root_d = '0;
      if (ctl_i.sqrt_op) begin
        cnt_d = wfs_pkg::STEP_CNT_W'(wfs_pkg::SQRT_STEPS);
        rad_d = radicand_i;
        rem_d = '0;
      end else begin
        cnt_d = wfs_pkg::STEP_CNT_W'(wfs_pkg::DIV_STEPS);
        rad_d = {34'd0, dividend_i[31:0]};
        rem_d = {4'd0, dividend_i[63:32]};
      end
    end else if (busy_q) begin
      rem_d = ge ? sub_r[wfs_pkg::REM_W-1:0] : sub_x;
      if (op_q) begin
        root_d = {root_q[wfs_pkg::ROOT_W-2:0], ge};
        rad_d  = {rad_q[wfs_pkg::RAD_W-3:0], 2'b00};
      end else begin
        rad_d = {rad_q[wfs_pkg::RAD_W-2:0], ge};
      end
      cnt_d = cnt_q - wfs_pkg::STEP_CNT_W'(1);
      if (cnt_q == wfs_pkg::STEP_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
  assign quot_o = rad_q[31:0];

endmodule

FILE: hdl/waypoint_follower_step_top.sv
// Top level: waypoint follower with command decode and tick sequencer.
// Commands other than a moving tick go straight to the done state after accept.
// A moving tick either snaps, lands after the bit-serial root (33 steps), or steps
// after the root and two divisions (32 steps each).
// One item at a time; the next item is taken while the last result waits.
// Reset (async, active low) clears position, route count, pointer, mode, speed, loop, output valid; snap goes to 256.
`timescale 1ns / 1ps
module waypoint_follower_step_top #(
  parameter int unsigned ROUTE_DEPTH = wfs_pkg::ROUTE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wfs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [wfs_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wfs_pkg::CMD_W-1:0]      cmd_i,
  input  logic [wfs_pkg::DT_W-1:0]       tick_dt_i,
  input  logic signed [31:0]             coord_x_i,
  input  logic signed [31:0]             coord_y_i,
  input  logic                           has_home_i,
  input  logic                           destroyed_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             pos_x_o,
  output logic signed [31:0]             pos_y_o,
  output logic [wfs_pkg::MODE_W-1:0]     motion_mode_o,
  output logic                           route_active_o,
  output logic [wfs_pkg::OUT_IDX_W-1:0]  current_index_o,
  output logic [wfs_pkg::OUT_LEN_W-1:0]  route_length_o
);

  localparam int unsigned IW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(ROUTE_DEPTH + 1);
  localparam int unsigned NW = 9;

  typedef enum logic [17:0] {
    ST_IDLE  = 18'b000000000000000001,
    ST_READ  = 18'b000000000000000010,
    ST_DIFF  = 18'b000000000000000100,
    ST_MUL_A = 18'b000000000000001000,
    ST_MUL_B = 18'b000000000000010000,
    ST_MUL_T = 18'b000000000000100000,
    ST_MUL_S = 18'b000000000001000000,
    ST_CHECK = 18'b000000000010000000,
    ST_SQRT  = 18'b000000000100000000,
    ST_DEN   = 18'b000000001000000000,
    ST_MUL_X = 18'b000000010000000000,
    ST_LD_X  = 18'b000000100000000000,
    ST_DIV_X = 18'b000001000000000000,
    ST_MUL_Y = 18'b000010000000000000,
    ST_LD_Y  = 18'b000100000000000000,
    ST_DIV_Y = 18'b001000000000000000,
    ST_APPLY = 18'b010000000000000000,
    ST_DONE  = 18'b100000000000000000
  } state_e;

  state_e                  state_q, state_d;
  logic [31:0]             pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [IW-1:0]           ptr_q, ptr_d;
  wfs_pkg::mode_e          mode_q, mode_d;
  logic [wfs_pkg::CFG_W-1:0] snap_q, speed_q;
  logic                    loop_q;

  logic                    out_valid_q;
  logic [31:0]             out_x_q, out_y_q;
  logic [wfs_pkg::MODE_W-1:0] out_mode_q;
  logic [CW-1:0]           out_cnt_q;
  logic [IW-1:0]           out_ptr_q;

  // Tick datapath registers
  logic [wfs_pkg::DT_W-1:0] dt_q;
  logic signed [32:0]      dx_q, dx_d, dy_q, dy_d;
  logic [31:0]             a_q, a_d, b_q, b_d;
  logic [63:0]             aa_q, aa_d, bb_q, bb_d;
  logic [47:0]             tt_q, tt_d;
  logic [31:0]             step_q, step_d, s_q, s_d, qx_q, qx_d;
  logic [wfs_pkg::DEN_W-1:0] den_q, den_d;

  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  logic [63:0]             mem_wdata, mem_rdata;
  logic [31:0]             mul_a, mul_b;
  logic [63:0]             prod;
  wfs_pkg::sqdiv_ctl_t     sd_ctl;
  logic                    sd_done;
  logic [wfs_pkg::ROOT_W-1:0] sd_root;
  logic [31:0]             sd_quot;
  logic [64:0]             sq_sum;
  logic [wfs_pkg::ROOT_W-1:0] den_full;
  logic [31:0]             wp_x, wp_y;
  logic                    in_acc, out_free;
  logic [NW-1:0]           ptr_n, cnt_n;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign wp_x       = mem_rdata[63:32];
  assign wp_y       = mem_rdata[31:0];
  assign ptr_n      = NW'(ptr_q) + NW'(1);
  assign cnt_n      = NW'(cnt_q);
  assign sq_sum     = {1'b0, aa_q} + {1'b0, bb_q};
  assign den_full   = (sd_root < wfs_pkg::ROOT_W'(256)) ? wfs_pkg::ROOT_W'(256) : sd_root;

  wfs_route_mem #(.DEPTH(ROUTE_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (ptr_q),
    .rdata_o (mem_rdata)
  );

  wfs_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  wfs_sqdiv u_sqdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (sd_ctl),
    .radicand_i ({1'b0, sq_sum}),
    .dividend_i (prod),
    .divisor_i  (den_q),
    .done_o     (sd_done),
    .root_o     (sd_root),
    .quot_o     (sd_quot)
  );

  // Steer the shared multiplier
  always_comb begin
    unique case (state_q)
      ST_MUL_A: begin mul_a = a_q;             mul_b = a_q; end
      ST_MUL_B: begin mul_a = b_q;             mul_b = b_q; end
      ST_MUL_T: begin mul_a = 32'(snap_q);     mul_b = 32'(snap_q); end
      ST_MUL_S: begin mul_a = 32'(speed_q);    mul_b = 32'(dt_q); end
      ST_MUL_Y: begin mul_a = b_q;             mul_b = s_q; end
      default:  begin mul_a = a_q;             mul_b = s_q; end
    endcase
  end

  // Sequencer and state update
  always_comb begin
    state_d   = state_q;
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    cnt_d     = cnt_q;
    ptr_d     = ptr_q;
    mode_d    = mode_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    a_d       = a_q;
    b_d       = b_q;
    aa_d      = aa_q;
    bb_d      = bb_q;
    tt_d      = tt_q;
    step_d    = step_q;
    s_d       = s_q;
    den_d     = den_q;
    qx_d      = qx_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = {coord_x_i, coord_y_i};
    sd_ctl    = '{start: 1'b0, sqrt_op: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_DONE;
          unique case (wfs_pkg::cmd_e'(cmd_i))
            wfs_pkg::CMD_TICK: begin
              if (!destroyed_i && mode_q != wfs_pkg::MODE_IDLE) begin
                if (cnt_q == '0) begin
                  mode_d = wfs_pkg::MODE_IDLE;
                end else if (NW'(ptr_q) >= cnt_n) begin
                  cnt_d  = '0;
                  ptr_d  = '0;
                  mode_d = wfs_pkg::MODE_IDLE;
                end else begin
                  state_d = ST_READ;
                end
              end
            end
            wfs_pkg::CMD_MOVE_TO: begin
              mem_we = 1'b1;
              cnt_d  = CW'(1);
              ptr_d  = '0;
              mode_d = wfs_pkg::MODE_MOVING;
            end
            wfs_pkg::CMD_WITHDRAW: begin
              ptr_d = '0;
              if (has_home_i) begin
                mem_we = 1'b1;
                cnt_d  = CW'(1);
                mode_d = wfs_pkg::MODE_WITHDRAW;
              end else begin
                cnt_d  = '0;
                mode_d = wfs_pkg::MODE_IDLE;
              end
            end
            wfs_pkg::CMD_HALT: begin
              cnt_d  = '0;
              ptr_d  = '0;
              mode_d = wfs_pkg::MODE_IDLE;
            end
            wfs_pkg::CMD_APPEND: begin
              if (cnt_n < NW'(ROUTE_DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = IW'(cnt_q);
                cnt_d     = cnt_q + CW'(1);
              end
            end
            wfs_pkg::CMD_SET_POS: begin
              pos_x_d = coord_x_i;
              pos_y_d = coord_y_i;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: state_d = ST_DIFF;
      ST_DIFF: begin
        dx_d    = 33'(signed'(wp_x)) - 33'(signed'(pos_x_q));
        dy_d    = 33'(signed'(wp_y)) - 33'(signed'(pos_y_q));
        a_d     = dx_d[32] ? 32'(-dx_d) : dx_d[31:0];
        b_d     = dy_d[32] ? 32'(-dy_d) : dy_d[31:0];
        state_d = ST_MUL_A;
      end
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: begin
        aa_d    = prod;
        state_d = ST_MUL_T;
      end
      ST_MUL_T: begin
        bb_d    = prod;
        state_d = ST_MUL_S;
      end
      ST_MUL_S: begin
        tt_d    = prod[47:0];
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        step_d = prod[39:8];
        // Snap onto the waypoint, then advance, wrap to the start when looping, or end the route
        if (a_q < 32'(snap_q) && b_q < 32'(snap_q) && sq_sum < 65'(tt_q)) begin
          pos_x_d = wp_x;
          pos_y_d = wp_y;
          state_d = ST_DONE;
          if (ptr_n < cnt_n) begin
            ptr_d = ptr_q + IW'(1);
          end else if (loop_q && cnt_n > NW'(1)) begin
            ptr_d = '0;
          end else begin
            cnt_d  = '0;
            ptr_d  = '0;
            mode_d = wfs_pkg::MODE_IDLE;
          end
        end else begin
          sd_ctl  = '{start: 1'b1, sqrt_op: 1'b1};
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sd_done) begin
          state_d = ST_DEN;
        end
      end
      ST_DEN: begin
        // Land on the waypoint when the step covers the distance
        if ({1'b0, step_q} >= den_full) begin
          pos_x_d = wp_x;
          pos_y_d = wp_y;
          state_d = ST_DONE;
        end else begin
          priority if (den_full[32]) begin
            s_d   = step_q >> 2;
            den_d = den_full[32:2];
          end else if (den_full[31]) begin
            s_d   = step_q >> 1;
            den_d = den_full[31:1];
          end else begin
            s_d   = step_q;
            den_d = den_full[30:0];
          end
          state_d = ST_MUL_X;
        end
      end
      ST_MUL_X: state_d = ST_LD_X;
      ST_LD_X: begin
        sd_ctl  = '{start: 1'b1, sqrt_op: 1'b0};
        state_d = ST_DIV_X;
      end
      ST_DIV_X: begin
        if (sd_done) begin
          qx_d    = sd_quot;
          state_d = ST_MUL_Y;
        end
      end
      ST_MUL_Y: state_d = ST_LD_Y;
      ST_LD_Y: begin
        sd_ctl  = '{start: 1'b1, sqrt_op: 1'b0};
        state_d = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        if (sd_done) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        pos_x_d = pos_x_q + (dx_q[32] ? -qx_q : qx_q);
        pos_y_d = pos_y_q + (dy_q[32] ? -sd_quot : sd_quot);
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
      cnt_q       <= '0;
      ptr_q       <= '0;
      mode_q      <= wfs_pkg::MODE_IDLE;
      snap_q      <= wfs_pkg::CFG_W'(wfs_pkg::SNAP_RESET);
      speed_q     <= '0;
      loop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      cnt_q   <= cnt_d;
      ptr_q   <= ptr_d;
      mode_q  <= mode_d;
      if (cfg_we_i) begin
        unique case (wfs_pkg::reg_e'(cfg_idx_i))
          wfs_pkg::REG_SNAP:  snap_q  <= cfg_data_i;
          wfs_pkg::REG_SPEED: speed_q <= cfg_data_i;
          wfs_pkg::REG_LOOP:  loop_q  <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath and result registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dt_q <= tick_dt_i;
    end
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    a_q    <= a_d;
    b_q    <= b_d;
    aa_q   <= aa_d;
    bb_q   <= bb_d;
    tt_q   <= tt_d;
    step_q <= step_d;
    s_q    <= s_d;
    den_q  <= den_d;
    qx_q   <= qx_d;
    if (state_q == ST_DONE && out_free) begin
      out_x_q    <= pos_x_q;
      out_y_q    <= pos_y_q;
      out_mode_q <= mode_q;
      out_cnt_q  <= cnt_q;
      out_ptr_q  <= ptr_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pos_x_o         = out_x_q;
  assign pos_y_o         = out_y_q;
  assign motion_mode_o   = out_mode_q;
  assign route_active_o  = (out_mode_q != wfs_pkg::MODE_IDLE);
  assign current_index_o = wfs_pkg::OUT_IDX_W'(out_ptr_q);
  assign route_length_o  = wfs_pkg::OUT_LEN_W'(out_cnt_q);

endmodule

FILE: hdl/wfs_checker.sv
// Port-level checker for the waypoint follower, bound to the top level.
`timescale 1ns / 1ps
module wfs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [wfs_pkg::MODE_W-1:0]    motion_mode_o,
  input logic                          route_active_o
);

  // A result stays offered until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // Only one item is worked on at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while one is in work");

  // Route is active exactly when the mode is not idle
  a_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (route_active_o == (motion_mode_o != wfs_pkg::MODE_IDLE)))
    else $error("route_active disagrees with motion_mode");

  // Mode code three is never reported
  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (motion_mode_o != 2'd3))
    else $error("invalid motion mode reported");

endmodule

bind waypoint_follower_step_top wfs_checker u_wfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .motion_mode_o  (motion_mode_o),
  .route_active_o (route_active_o)
);
